// File: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

  // Operation codes carried in the mode field of an input transaction.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Bits in one output byte.
  localparam int unsigned BYTE_BITS = 8;

  // Most bytes one input transaction can produce.
  localparam int unsigned MAX_BURST = 4;

  // Width of the stored code word.
  localparam int unsigned CODE_W = 32;

  // Width of a stored code length.
  localparam int unsigned LEN_W = 6;

  // Width of the pending bit register and its count.
  localparam int unsigned PEND_W  = 7;
  localparam int unsigned PCNT_W  = 3;

  // Table read result: the code and its length (zero for a symbol never loaded).
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } lookup_t;

  // Bytes produced by one transaction, right-aligned, first byte most significant.
  typedef struct packed {
    logic [CODE_W-1:0] bytes;
    logic [2:0]        count;
  } burst_t;

endpackage

// File: hw/rtl/hcbp_if.sv
// Input channel: one load, encode or finish command per transaction.
interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  symbol;
  logic [31:0] code_word;
  logic [5:0]  code_length;

  modport source (output valid, output mode, output symbol, output code_word,
                  output code_length, input ready);
  modport sink   (input valid, input mode, input symbol, input code_word,
                  input code_length, output ready);
endinterface

// Result channel: one packed byte per transaction.
interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: hw/rtl/hcbp_ram.sv
module hcbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/hcbp_code_table.sv
module hcbp_code_table
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned AW           = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CODE_W-1:0] wcode,
  input  logic [LEN_W-1:0]  wlen,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output lookup_t           rd
);

  logic [SYMBOL_COUNT-1:0] len_valid_r;
  logic                    rd_valid_r;
  logic [CODE_W-1:0]       code_q;
  logic [LEN_W-1:0]        len_q;

  hcbp_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcode),
    .re    (re),
    .raddr (raddr),
    .rdata (code_q)
  );

  hcbp_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOL_COUNT)) u_len_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wlen),
    .re    (re),
    .raddr (raddr),
    .rdata (len_q)
  );

  // One valid bit per entry; an entry never written reads as length zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_valid_r <= '0;
    end else if (we) begin
      len_valid_r[waddr] <= 1'b1;
    end
  end

  // The valid bit is read alongside the memories so it lines up with their data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (re) begin
      rd_valid_r <= len_valid_r[raddr];
    end
  end

  assign rd.code = code_q;
  assign rd.len  = rd_valid_r ? len_q : '0;

endmodule

// File: hw/rtl/hcbp_packer.sv
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic [1:0] item_mode,
  input  logic       item_in_range,
  input  lookup_t    lookup,
  input  logic       advance,
  output burst_t     burst,
  output logic [PCNT_W-1:0] pend_cnt
);

  localparam int unsigned ACC_W = CODE_W + PEND_W;

  logic [PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic [CODE_W:0]   len_mask;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [2:0]        rem;
  logic [ACC_W-1:0]  acc_shr;
  logic [3:0]        pad;
  logic [BYTE_BITS-1:0] padded;
  logic              do_encode;

  // Append the code below the pending bits and split the result into whole bytes.
  always_comb begin
    len_mask = ~({(CODE_W+1){1'b1}} << lookup.len);
    acc      = ({{CODE_W{1'b0}}, pend_bits_r} << lookup.len)
             | {{PEND_W{1'b0}}, lookup.code & len_mask[CODE_W-1:0]};
    total    = {{(LEN_W-PCNT_W){1'b0}}, pend_cnt_r} + lookup.len;
    rem      = total[2:0];
    acc_shr  = acc >> rem;
  end

  // Finish pads the partial byte with zeros at the low end.
  always_comb begin
    pad    = (pend_cnt_r == '0) ? 4'd0 : (4'd8 - {1'b0, pend_cnt_r});
    padded = 8'({1'b0, pend_bits_r} << pad);
  end

  assign do_encode = item_valid && (item_mode == MODE_ENCODE) && item_in_range
                     && (lookup.len != '0);

  // Bytes handed to the emitter and the pending state after this transaction.
  always_comb begin
    burst         = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (do_encode) begin
      burst.bytes   = acc_shr[CODE_W-1:0];
      burst.count   = total[5:3];
      pend_bits_nxt = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
      pend_cnt_nxt  = rem;
    end else if (item_valid && (item_mode == MODE_FINISH)) begin
      if (pend_cnt_r != '0) begin
        burst.bytes = {16'd0, padded, 4'd0, pad};
        burst.count = 3'd2;
      end else begin
        burst.bytes = '0;
        burst.count = 3'd1;
      end
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end
  end

  // Pending bits move only when the transaction leaves the lookup stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (advance) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  assign pend_cnt = pend_cnt_r;

endmodule

// File: hw/rtl/hcbp_emitter.sv
module hcbp_emitter
  import hcbp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   can_take,
  hcbp_out_if.source out_ch
);

  logic [CODE_W-1:0] word_r;
  logic [2:0]        cnt_r;
  logic [1:0]        idx;
  logic              out_fire;

  assign out_fire = out_ch.valid && out_ch.ready;

  // Free now, or freeing as the final byte of the current burst goes out.
  assign can_take = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ch.ready);

  // Hold a burst and count its bytes down as they are taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= burst.bytes;
    end
  end

  // The byte shown is the highest one still left in the burst.
  assign idx             = 2'(cnt_r - 3'd1);
  assign out_ch.valid    = (cnt_r != 3'd0);
  assign out_ch.out_byte = word_r[{idx, 3'b000} +: BYTE_BITS];
  assign out_ch.last     = (cnt_r == 3'd1);

endmodule

// File: hw/rtl/huffman_code_bit_packer.sv
// Channel   Direction  Payload                                    Transaction when
// in_ch     sink       mode, symbol, code_word, code_length       valid && ready
// out_ch    source     out_byte, last                             valid && ready
//
// An encode reads the code table as it is accepted, passes through the lookup
// stage and is loaded into the output register of the emitter; its bytes then
// leave one per cycle while out_ch is ready, up to four bytes per item.
// The one-byte output port sets that rate. A command that completes bytes
// waits in the lookup stage until the output register is empty or sending its
// final byte, so the input stalls while a longer burst drains; commands that
// complete no byte pass at one per cycle.
// Reset (rst_n low, synchronous) clears the pending bits and all code lengths
// at once through per-entry valid bits; no clearing pass is needed.
// A stall on out_ch holds the lookup stage and then the input.
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic clk,
  input  logic rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  localparam int unsigned AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP_W = LEN_W'(LEN_CAP);
  localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);

  logic           in_fire;
  logic           sym_ok;
  logic           tbl_we;
  logic           tbl_re;
  logic [LEN_W-1:0] len_sat;
  lookup_t        lookup;
  burst_t         burst;
  logic [PCNT_W-1:0] pend_cnt;
  logic           can_take;
  logic           s1_adv;
  logic           emit_load;

  logic           s1_valid_r;
  logic [1:0]     s1_mode_r;
  logic           s1_in_range_r;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign sym_ok  = ({1'b0, in_ch.symbol} < SYM_LIMIT);
  assign len_sat = (in_ch.code_length > LEN_CAP_W) ? LEN_CAP_W : in_ch.code_length;

  // Loads write the table at acceptance; encodes read it for the next stage.
  assign tbl_we = in_fire && (in_ch.mode == MODE_LOAD) && sym_ok;
  assign tbl_re = in_fire && (in_ch.mode == MODE_ENCODE);

  hcbp_code_table #(.SYMBOL_COUNT(SYMBOL_COUNT), .AW(AW)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (tbl_we),
    .waddr (in_ch.symbol[AW-1:0]),
    .wcode (in_ch.code_word),
    .wlen  (len_sat),
    .re    (tbl_re),
    .raddr (in_ch.symbol[AW-1:0]),
    .rd    (lookup)
  );

  // Lookup stage: one command whose table data is arriving.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r     <= in_ch.mode;
      s1_in_range_r <= sym_ok;
    end
  end

  hcbp_packer u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (s1_valid_r),
    .item_mode     (s1_mode_r),
    .item_in_range (s1_in_range_r),
    .lookup        (lookup),
    .advance       (s1_adv),
    .burst         (burst),
    .pend_cnt      (pend_cnt)
  );

  // A command with no bytes leaves at once; otherwise it waits for the emitter.
  assign s1_adv      = s1_valid_r && ((burst.count == 3'd0) || can_take);
  assign emit_load   = s1_adv && (burst.count != 3'd0);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  hcbp_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit_load),
    .burst    (burst),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  // A finish always leaves nothing pending.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_mode_r == MODE_FINISH)) |=> (pend_cnt == '0))
    else $error("pending bits remain after finish");

  // One command never yields more bytes than the emitter holds.
  a_burst_fits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (burst.count <= 3'(MAX_BURST)))
    else $error("burst larger than emitter capacity");

  // Table data must hold while the lookup stage is stalled.
  a_lookup_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(lookup))
    else $error("table read data changed during a stall");

endmodule
